[src/ptts_pkg.sv]
// Shared constants and types for the periodic task tick scheduler.
`default_nettype none

package ptts_pkg;

    localparam int unsigned TASK_SLOTS_DEF = 32;
    localparam int unsigned IDX_W = 6;
    localparam int unsigned CNT_W = 7;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;
    localparam logic MODE_RM  = 1'b0;
    localparam logic MODE_EDF = 1'b1;
    localparam logic CFG_SCHED_MODE = 1'b0;
    localparam logic CFG_TASK_COUNT = 1'b1;

    // Candidate record that moves one cell per cycle along the chain.
    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
        logic [31:0]      key;
        logic [15:0]      rem;
        logic             pmiss;
        logic             wmiss;
        logic [CNT_W-1:0] cnt;
    } t_link;

    // Control broadcast from the sequencer to every cell.
    typedef struct packed {
        logic             load_en;
        logic [IDX_W-1:0] load_idx;
        logic [15:0]      exec_time;
        logic [15:0]      period;
        logic [15:0]      rel_deadline;
        logic             rel_en;
        logic             run_en;
        logic             found;
        logic [IDX_W-1:0] win_idx;
        logic [31:0]      time_now;
        logic [32:0]      time_p1;
        logic [CNT_W-1:0] task_n;
        logic             mode;
    } t_cell_ctl;

endpackage

`default_nettype wire

[src/ptts_cell.sv]
// One task cell: holds a task entry and its job state, and forwards the best candidate.
`default_nettype none

module ptts_cell import ptts_pkg::*; #(
    parameter int unsigned CELL_IDX = 0
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_cell_ctl i_ctl,
    input  wire t_link     i_link,
    output t_link          o_link,
    output logic           o_miss
);

    logic [15:0] r_exec, r_period, r_dl, r_rem;
    logic [31:0] r_rel, r_due;
    t_link       r_link, n_link;
    logic        w_active, w_overdue, w_pmiss, w_wmiss, w_take, w_win;
    logic [31:0] w_key;
    logic [IDX_W-1:0] w_me;

    always_comb begin
        w_me      = IDX_W'(CELL_IDX);
        w_active  = CNT_W'(CELL_IDX) < i_ctl.task_n;
        w_overdue = i_ctl.time_p1 >= {1'b0, r_due};
        w_pmiss   = w_active && (r_rem != 16'd0) && w_overdue;
        w_wmiss   = w_active && (r_rem > 16'd1) && w_overdue;
        w_key     = (i_ctl.mode == MODE_EDF) ? r_due : {16'd0, r_period};
        w_take    = w_active && (r_rem != 16'd0) && (!i_link.found || (w_key < i_link.key));
        w_win     = i_ctl.found && (i_ctl.win_idx == w_me);
        o_miss    = w_active && (w_win ? w_wmiss : w_pmiss);
        n_link    = i_link;
        if (w_take) begin
            n_link.found = 1'b1;
            n_link.idx   = w_me;
            n_link.key   = w_key;
            n_link.rem   = r_rem;
            n_link.pmiss = w_pmiss;
            n_link.wmiss = w_wmiss;
        end
        n_link.cnt = i_link.cnt + CNT_W'(w_pmiss);
    end

    assign o_link = r_link;

    always_ff @(posedge i_clk) begin
        r_link <= n_link;
        if (i_ctl.load_en && (i_ctl.load_idx == w_me)) begin
            r_exec   <= i_ctl.exec_time;
            r_period <= i_ctl.period;
            r_dl     <= i_ctl.rel_deadline;
        end
        if (!i_rst_n) begin
            r_rem <= '0;
            r_rel <= '0;
            r_due <= '0;
        end else if (i_ctl.load_en && (i_ctl.load_idx == w_me)) begin
            r_rem <= '0;
            r_rel <= '0;
            r_due <= '0;
        end else if (i_ctl.rel_en && w_active && (r_rel == i_ctl.time_now)) begin
            r_rem <= r_exec;
            r_due <= i_ctl.time_now + {16'd0, r_dl};
            r_rel <= i_ctl.time_now + {16'd0, r_period};
        end else if (i_ctl.run_en && w_win) begin
            r_rem <= r_rem - 16'd1;
        end
    end

endmodule

`default_nettype wire

[src/periodic_task_tick_scheduler.sv]
// Top level of the periodic task tick scheduler: sequencer, totals and the chain of task cells.
//
//   channel | direction | handshake                  | payload
//   in      | input     | i_in_valid / o_in_ready    | command, task_index, exec_time, period,
//           |           |                            | rel_deadline
//   out     | output    | o_out_valid / i_out_ready  | run_valid .. miss_total
//   cfg     | input     | i_cfg_we (no handshake)    | i_cfg_index, i_cfg_data
//
// A load transaction gives no result and leaves the block idle. A tick transaction passes
// through the release state, then the scan state, in which the candidate record ripples
// through the cell chain one cell per cycle, then the run state, which registers the
// result, and then returns to the idle state, in which the next transaction is taken.
// The run state waits while an earlier result is still held on the output channel.
// Reset is synchronous and active low; it clears job state, time, totals, configuration
// and the sequencer and valid registers, but not the result payload or chain registers.
// The task table itself holds undefined values until a load writes it.
`default_nettype none

module periodic_task_tick_scheduler import ptts_pkg::*; #(
    parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_we,
    input  wire logic        i_cfg_index,
    input  wire logic [5:0]  i_cfg_data,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic        i_command,
    input  wire logic [4:0]  i_task_index,
    input  wire logic [15:0] i_exec_time,
    input  wire logic [15:0] i_period,
    input  wire logic [15:0] i_rel_deadline,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic             o_run_valid,
    output logic [4:0]       o_run_task,
    output logic [15:0]      o_run_remaining,
    output logic             o_switch_flag,
    output logic [31:0]      o_miss_mask,
    output logic [5:0]       o_miss_count,
    output logic [31:0]      o_idle_total,
    output logic [31:0]      o_switch_total,
    output logic [31:0]      o_miss_total
);

    localparam int unsigned SC_W   = $clog2(TASK_SLOTS + 1);
    localparam int unsigned MASK_N = (TASK_SLOTS < 32) ? TASK_SLOTS : 32;

    typedef enum logic [1:0] {S_IDLE, S_REL, S_SCAN, S_RUN} t_state;

    t_state           r_state;
    logic [SC_W-1:0]  r_scan;
    logic             r_mode;
    logic [5:0]       r_task_count;
    logic [31:0]      r_time;
    logic             r_last_valid;
    logic [IDX_W-1:0] r_last_idx;
    logic [31:0]      r_idle_cnt, r_switch_cnt, r_miss_tally;

    t_cell_ctl        w_ctl;
    t_link            w_link [TASK_SLOTS+1];
    logic [TASK_SLOTS-1:0] w_miss;
    t_link            w_fin;
    logic [CNT_W-1:0] w_cnt;
    logic             w_accept, w_run, w_sw;
    logic [32:0]      w_idle_sum, w_sw_sum, w_miss_sum;

    assign o_in_ready = (r_state == S_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_run      = (r_state == S_RUN) && (!o_out_valid || i_out_ready);
    assign w_fin      = w_link[TASK_SLOTS];

    // The chain starts each scan from an empty candidate with a zero miss count.
    assign w_link[0] = '0;

    always_comb begin
        w_ctl.load_en      = w_accept && (i_command == CMD_LOAD);
        w_ctl.load_idx     = {1'b0, i_task_index};
        w_ctl.exec_time    = i_exec_time;
        w_ctl.period       = i_period;
        w_ctl.rel_deadline = i_rel_deadline;
        w_ctl.rel_en       = (r_state == S_REL);
        w_ctl.run_en       = w_run;
        w_ctl.found        = w_fin.found;
        w_ctl.win_idx      = w_fin.idx;
        w_ctl.time_now     = r_time;
        w_ctl.time_p1      = {1'b0, r_time} + 33'd1;
        w_ctl.task_n       = ({1'b0, r_task_count} > CNT_W'(TASK_SLOTS)) ?
                             CNT_W'(TASK_SLOTS) : {1'b0, r_task_count};
        w_ctl.mode         = r_mode;
    end

    for (genvar g = 0; g < TASK_SLOTS; g++) begin : g_cell
        ptts_cell #(.CELL_IDX(g)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (w_ctl),
            .i_link  (w_link[g]),
            .o_link  (w_link[g+1]),
            .o_miss  (w_miss[g])
        );
    end

    // The chain counted every overdue task as if it did not run; the winner's own
    // overdue test is redone with its work after this tick's unit.
    always_comb begin
        w_cnt = w_fin.cnt;
        if (w_fin.found) begin
            w_cnt = w_fin.cnt - CNT_W'(w_fin.pmiss) + CNT_W'(w_fin.wmiss);
        end
        w_sw       = w_fin.found && r_last_valid && (r_last_idx != w_fin.idx);
        w_idle_sum = {1'b0, r_idle_cnt} + 33'(!w_fin.found);
        w_sw_sum   = {1'b0, r_switch_cnt} + 33'(w_sw);
        w_miss_sum = {1'b0, r_miss_tally} + 33'(w_cnt);
    end

    assign o_idle_total   = r_idle_cnt;
    assign o_switch_total = r_switch_cnt;
    assign o_miss_total   = r_miss_tally;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_scan       <= '0;
            r_mode       <= MODE_RM;
            r_task_count <= '0;
            r_time       <= '0;
            r_last_valid <= 1'b0;
            r_last_idx   <= '0;
            r_idle_cnt   <= '0;
            r_switch_cnt <= '0;
            r_miss_tally <= '0;
            o_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    CFG_SCHED_MODE: r_mode       <= i_cfg_data[0];
                    CFG_TASK_COUNT: r_task_count <= i_cfg_data;
                    default:        r_mode       <= r_mode;
                endcase
            end
            // A new result replaces the one taken in the same cycle.
            if (o_out_valid && i_out_ready && !w_run) begin
                o_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (i_command == CMD_TICK)) begin
                        r_state <= S_REL;
                    end
                end
                S_REL: begin
                    r_scan  <= '0;
                    r_state <= S_SCAN;
                end
                S_SCAN: begin
                    r_scan <= r_scan + SC_W'(1);
                    if (r_scan == SC_W'(TASK_SLOTS - 1)) begin
                        r_state <= S_RUN;
                    end
                end
                S_RUN: begin
                    if (w_run) begin
                        r_state         <= S_IDLE;
                        o_out_valid     <= 1'b1;
                        o_run_valid     <= w_fin.found;
                        o_run_task      <= w_fin.found ? w_fin.idx[4:0] : 5'd0;
                        o_run_remaining <= w_fin.found ? (w_fin.rem - 16'd1) : 16'd0;
                        o_switch_flag   <= w_sw;
                        o_miss_mask     <= 32'(w_miss[MASK_N-1:0]);
                        o_miss_count    <= (w_cnt > CNT_W'(63)) ? 6'd63 : w_cnt[5:0];
                        r_idle_cnt      <= w_idle_sum[32] ? 32'hFFFF_FFFF : w_idle_sum[31:0];
                        r_switch_cnt    <= w_sw_sum[32] ? 32'hFFFF_FFFF : w_sw_sum[31:0];
                        r_miss_tally    <= w_miss_sum[32] ? 32'hFFFF_FFFF : w_miss_sum[31:0];
                        r_last_valid    <= w_fin.found;
                        r_last_idx      <= w_fin.found ? w_fin.idx : '0;
                        r_time          <= r_time + 32'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[src/ptts_checker.sv]
// Port-level checks for the periodic task tick scheduler, bound to its top level.
`default_nettype none

module ptts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_out_valid,
    input wire logic        i_out_ready,
    input wire logic        o_run_valid,
    input wire logic [4:0]  o_run_task,
    input wire logic [15:0] o_run_remaining,
    input wire logic        o_switch_flag,
    input wire logic [31:0] o_miss_mask,
    input wire logic [5:0]  o_miss_count,
    input wire logic [31:0] o_idle_total
);

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result transaction dropped before it was taken");

    a_idle_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_run_valid |-> (o_run_task == 5'd0) && (o_run_remaining == 16'd0)
            && !o_switch_flag)
        else $error("idle tick reports a running task");

    a_mask_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> $countones(o_miss_mask) <= o_miss_count)
        else $error("miss count below the number of flagged tasks");

    a_idle_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> o_idle_total >= $past(o_idle_total))
        else $error("idle total decreased");

endmodule

bind periodic_task_tick_scheduler ptts_checker u_ptts_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_out_valid     (o_out_valid),
    .i_out_ready     (i_out_ready),
    .o_run_valid     (o_run_valid),
    .o_run_task      (o_run_task),
    .o_run_remaining (o_run_remaining),
    .o_switch_flag   (o_switch_flag),
    .o_miss_mask     (o_miss_mask),
    .o_miss_count    (o_miss_count),
    .o_idle_total    (o_idle_total)
);

`default_nettype wire

[dv/tb.sv]
// Self-checking testbench for the periodic task tick scheduler.
`default_nettype none

module tb import ptts_pkg::*;;

    localparam int NSLOT = 32;
    localparam int DRAIN_CYCLES = 45;
    localparam int STALL_LIMIT = 3000;    // cycles without any transaction
    localparam int HOLD_CYCLES = 300;     // long receiver hold-off

    // One result transaction of the output channel.
    typedef struct packed {
        logic        run_valid;
        logic [4:0]  run_task;
        logic [15:0] run_remaining;
        logic        switch_flag;
        logic [31:0] miss_mask;
        logic [5:0]  miss_count;
        logic [31:0] idle_total;
        logic [31:0] switch_total;
        logic [31:0] miss_total;
    } sched_result_t;

    // One row of the directed table: a task entry load.
    typedef struct packed {
        logic [4:0]  idx;
        logic [15:0] exec_t;
        logic [15:0] per;
        logic [15:0] dl;
    } load_row_t;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_index;
    logic [5:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic        i_command;
    logic [4:0]  i_task_index;
    logic [15:0] i_exec_time;
    logic [15:0] i_period;
    logic [15:0] i_rel_deadline;
    logic        o_out_valid;
    logic        i_out_ready;
    sched_result_t got;

    periodic_task_tick_scheduler DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_command      (i_command),
        .i_task_index   (i_task_index),
        .i_exec_time    (i_exec_time),
        .i_period       (i_period),
        .i_rel_deadline (i_rel_deadline),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_run_valid    (got.run_valid),
        .o_run_task     (got.run_task),
        .o_run_remaining(got.run_remaining),
        .o_switch_flag  (got.switch_flag),
        .o_miss_mask    (got.miss_mask),
        .o_miss_count   (got.miss_count),
        .o_idle_total   (got.idle_total),
        .o_switch_total (got.switch_total),
        .o_miss_total   (got.miss_total)
    );

    // Shadow copy of the scheduler state, kept in step with every accepted transaction.
    logic [31:0] now_ticks;
    logic [15:0] exec_tab[NSLOT];
    logic [15:0] period_tab[NSLOT];
    logic [15:0] deadline_tab[NSLOT];
    logic [15:0] work_left[NSLOT];
    logic [31:0] rel_at[NSLOT];
    logic [31:0] abs_due[NSLOT];
    logic        prev_ran;
    logic [5:0]  prev_task;
    logic [31:0] idle_sum;
    logic [31:0] switch_sum;
    logic [31:0] miss_sum;
    logic        mode_sel;
    int          active_tasks;

    sched_result_t due_results[$];   // results still owed by the block
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_idle_pct = 0;
    bit          hold_req = 0;
    bit          hold_seen = 0;
    int          hold_left = 0;
    int          quiet_cycles = 0;

    // 20 time unit clock.
    always begin
        i_clk = 1'b1;
        #10;
        i_clk = 1'b0;
        #10;
    end

    function automatic logic [31:0] sat_inc(logic [31:0] v);
        return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
    endfunction

    // A load writes one entry and clears its job, so it next releases at time zero.
    function automatic void apply_load(logic [4:0] k, logic [15:0] e, logic [15:0] p,
                                       logic [15:0] d);
        exec_tab[k] = e;
        period_tab[k] = p;
        deadline_tab[k] = d;
        work_left[k] = '0;
        rel_at[k] = '0;
        abs_due[k] = '0;
    endfunction

    // One tick: release, pick by period or absolute deadline, run one unit, report misses.
    function automatic sched_result_t advance_tick();
        sched_result_t r;
        int  n;
        int  best;
        bit  found;
        int  cnt;
        r = '0;
        n = (active_tasks > NSLOT) ? NSLOT : active_tasks;
        best = 0;
        found = 0;
        cnt = 0;
        for (int i = 0; i < n; i++) begin
            if (rel_at[i] == now_ticks) begin
                work_left[i] = exec_tab[i];
                abs_due[i] = now_ticks + 32'(deadline_tab[i]);
                rel_at[i] = now_ticks + 32'(period_tab[i]);
            end
        end
        for (int i = 0; i < n; i++) begin
            if (work_left[i] != 0) begin
                if (!found) begin
                    best = i;
                    found = 1;
                end else if (mode_sel == MODE_RM) begin
                    if (period_tab[i] < period_tab[best]) best = i;
                end else begin
                    if (abs_due[i] < abs_due[best]) best = i;
                end
            end
        end
        if (found) begin
            if (prev_ran && prev_task != 6'(best)) begin
                r.switch_flag = 1'b1;
                switch_sum = sat_inc(switch_sum);
            end
            work_left[best] = work_left[best] - 16'd1;
            r.run_valid = 1'b1;
            r.run_task = 5'(best);
            r.run_remaining = work_left[best];
        end else begin
            idle_sum = sat_inc(idle_sum);
        end
        prev_ran = found;
        prev_task = found ? 6'(best) : '0;
        // The overdue test compares the next time without wrap against the due time.
        for (int i = 0; i < n; i++) begin
            if (work_left[i] > 0 && ({1'b0, now_ticks} + 33'd1) >= {1'b0, abs_due[i]}) begin
                r.miss_mask[i] = 1'b1;
                if (cnt < 63) cnt++;
                miss_sum = sat_inc(miss_sum);
            end
        end
        now_ticks = now_ticks + 32'd1;
        r.miss_count = 6'(cnt);
        r.idle_total = idle_sum;
        r.switch_total = switch_sum;
        r.miss_total = miss_sum;
        return r;
    endfunction

    // Offer one transaction and hold it until the block takes it.
    task automatic send_item(logic cmd, logic [4:0] k, logic [15:0] e, logic [15:0] p,
                             logic [15:0] d);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_command <= cmd;
        i_task_index <= k;
        i_exec_time <= e;
        i_period <= p;
        i_rel_deadline <= d;
        do @(posedge i_clk); while (!o_in_ready);
        if (cmd == CMD_LOAD) apply_load(k, e, p, d);
        else due_results.push_back(advance_tick());
    endtask

    // Wait until every owed result has come, then let a possible load finish.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (due_results.size() > 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // Both registers are written back to back on an idle block.
    task automatic set_config(logic mode, logic [5:0] count);
        i_cfg_we <= 1'b1;
        i_cfg_index <= CFG_SCHED_MODE;
        i_cfg_data <= {5'd0, mode};
        @(posedge i_clk);
        i_cfg_index <= CFG_TASK_COUNT;
        i_cfg_data <= count;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mode_sel = mode;
        active_tasks = count;
    endtask

    // Mostly ticks; a few loads, some with well-formed small values and some full range.
    // A load after time has moved on retires that task, so loads are kept rare.
    task automatic random_phase(int ticks);
        for (int j = 0; j < ticks; j++) begin
            if ($urandom_range(99) < 4) begin
                if ($urandom_range(1) == 0)
                    send_item(CMD_LOAD, 5'($urandom), 16'($urandom), 16'($urandom_range(65535, 1)),
                              16'($urandom));
                else
                    send_item(CMD_LOAD, 5'($urandom), 16'($urandom_range(3, 1)),
                              16'($urandom_range(80, 10)), 16'($urandom_range(60)));
            end else begin
                send_item(CMD_TICK, '0, '0, 16'd1, '0);
            end
        end
    endtask

    // Directed loads: the field extremes, zero execution time, the shortest period,
    // zero deadline (overdue at once) and a job too long to ever finish.
    load_row_t load_table[] = '{
        '{5'd0,  16'd2,     16'd12,    16'd0},
        '{5'd1,  16'd0,     16'd1,     16'd0},
        '{5'd2,  16'd65535, 16'd65535, 16'd65535},
        '{5'd3,  16'd3,     16'd20,    16'd20},
        '{5'd4,  16'd1,     16'd12,    16'd5},
        '{5'd5,  16'd2,     16'd30,    16'd3},
        '{5'd31, 16'd4,     16'd40,    16'd65535},
        '{5'd31, 16'd2,     16'd40,    16'd25}
    };

    // Output channel: check each accepted result, then choose the next ready.
    always @(posedge i_clk) begin
        sched_result_t want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (due_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %p", got);
            end else begin
                want = due_results.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, got);
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog on cycles in which neither channel moves a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: errors");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_SCHED_MODE;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_command = CMD_LOAD;
        i_task_index = '0;
        i_exec_time = '0;
        i_period = 16'd1;
        i_rel_deadline = '0;
        i_out_ready = 1'b0;
        now_ticks = '0;
        for (int i = 0; i < NSLOT; i++) apply_load(5'(i), '0, '0, '0);
        prev_ran = 1'b0;
        prev_task = '0;
        idle_sum = '0;
        switch_sum = '0;
        miss_sum = '0;
        mode_sel = MODE_RM;
        active_tasks = 0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Every entry is loaded at time zero so that no tick reads an empty entry.
        send_idle_pct = 33;
        recv_idle_pct = 87;
        for (int i = 6; i < 31; i++)
            send_item(CMD_LOAD, 5'(i), 16'($urandom_range(3, 1)), 16'($urandom_range(80, 10)),
                      16'($urandom_range(60)));
        foreach (load_table[r])
            send_item(CMD_LOAD, load_table[r].idx, load_table[r].exec_t, load_table[r].per,
                      load_table[r].dl);
        drain();
        set_config(MODE_RM, 6'd32);
        // Directed ticks over the full table; the receiver then stalls for a long stretch.
        for (int j = 0; j < 15; j++) send_item(CMD_TICK, '0, '0, 16'd1, '0);
        hold_req = 1'b1;
        random_phase(380);
        drain();

        send_idle_pct = 87;
        recv_idle_pct = 33;
        set_config(MODE_EDF, 6'd32);
        random_phase(380);
        drain();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(MODE_RM, 6'd12);
        random_phase(350);
        drain();
        set_config(MODE_EDF, 6'd5);
        random_phase(350);
        drain();
        // No task takes part: every tick is idle.
        set_config(MODE_RM, 6'd0);
        random_phase(60);
        drain();
        set_config(MODE_EDF, 6'd32);
        random_phase(300);
        drain();

        if (mismatches == 0 && due_results.size() == 0) begin
            $display("tb: clean");
        end else begin
            $display("tb: errors");
        end
        $finish;
    end

endmodule

`default_nettype wire
